// ===== sv/pwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsd_pkg
// Shared types and constants for the pulse width span discriminator: field
// widths, register indexes and the structs passed between the lanes and the
// merge stage.
// ----------------------------------------------------------------------------
package pwsd_pkg;

  // Field widths fixed by the interface.
  localparam int BIN_W   = 13;
  localparam int LANE_W  = 6;
  localparam int CHAN_W  = 64;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Bins at or above this index are ignored (frame start is still honored).
  localparam int TIME_BINS = 8192;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_MIN_WIDTH = 1'b0;
  localparam logic [0:0] REG_MIN_SPAN  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [BIN_W-1:0] MIN_WIDTH_RST = BIN_W'(10);
  localparam logic [BIN_W-1:0] MIN_SPAN_RST  = BIN_W'(50);

  // Thresholds seen by every lane.
  typedef struct packed {
    logic [BIN_W-1:0] min_width;
    logic [BIN_W-1:0] min_span;
  } pwsd_cfg_t;

  // Per-bin command broadcast to every lane.
  typedef struct packed {
    logic             clear;    // frame start on an accepted word
    logic             process;  // accepted word with a bin in range
    logic [BIN_W-1:0] bin;
  } pwsd_step_t;

  // What one lane found in the current bin.
  typedef struct packed {
    logic             acc;      // a pulse ended here and passed both tests
    logic [BIN_W-1:0] start;    // its start bin
  } pwsd_lane_res_t;

endpackage

// ===== sv/pwsd_lane.sv =====
// ----------------------------------------------------------------------------
// pwsd_lane
// One channel lane: tracks the open pulse and the last accepted start, and
// flags a pulse that ends in this bin and passes the width and span tests.
// ----------------------------------------------------------------------------
module pwsd_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pwsd_pkg::pwsd_cfg_t     cfg,
  input  pwsd_pkg::pwsd_step_t    step,
  input  logic                    hit,
  output pwsd_pkg::pwsd_lane_res_t res
);
  import pwsd_pkg::*;

  logic             in_pulse_r, in_pulse_nxt;
  logic [BIN_W-1:0] start_r, start_nxt;
  logic [BIN_W-1:0] las_r, las_nxt;

  // State as seen by this bin, after a frame start has cleared it.
  logic             ip_eff;
  logic [BIN_W-1:0] start_eff;
  logic [BIN_W-1:0] las_eff;

  logic [BIN_W:0]   width_diff;
  logic [BIN_W:0]   span_diff;
  logic             width_ok;
  logic             span_ok;
  logic             falling;
  logic             pass;

  assign ip_eff    = step.clear ? 1'b0 : in_pulse_r;
  assign start_eff = step.clear ? '0 : start_r;
  assign las_eff   = step.clear ? '0 : las_r;

  // Signed differences: the top bit marks a negative result.
  assign width_diff = {1'b0, step.bin} - {1'b0, start_eff};
  assign span_diff  = {1'b0, start_eff} - {1'b0, las_eff};
  assign width_ok   = !width_diff[BIN_W] && (width_diff[BIN_W-1:0] >= cfg.min_width);
  assign span_ok    = (las_eff == '0) ||
                      (!span_diff[BIN_W] && (span_diff[BIN_W-1:0] >= cfg.min_span));

  assign falling = step.process && !hit && ip_eff;
  assign pass    = falling && width_ok && span_ok;

  assign res.acc   = pass;
  assign res.start = start_eff;

  // Edge tracking and accepted-start bookkeeping.
  always_comb begin
    in_pulse_nxt = ip_eff;
    start_nxt    = start_eff;
    las_nxt      = las_eff;
    if (step.process && hit && !ip_eff) begin
      in_pulse_nxt = 1'b1;
      start_nxt    = step.bin;
    end else if (falling) begin
      in_pulse_nxt = 1'b0;
      if (pass) begin
        las_nxt = start_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pulse_r <= 1'b0;
      start_r    <= '0;
      las_r      <= '0;
    end else begin
      in_pulse_r <= in_pulse_nxt;
      start_r    <= start_nxt;
      las_r      <= las_nxt;
    end
  end

endmodule

// ===== sv/pwsd_merge.sv =====
// ----------------------------------------------------------------------------
// pwsd_merge
// Merge stage: takes one bin's accepted pulses from all lanes, emits them one
// per cycle while out_ready allows, ascending by lane, via an output register.
// ----------------------------------------------------------------------------
module pwsd_merge #(
  parameter int LANES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [pwsd_pkg::BIN_W-1:0] end_bin,
  input  pwsd_pkg::pwsd_lane_res_t lane_res [LANES],
  output logic                     take_ok,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [pwsd_pkg::LANE_W-1:0] out_lane,
  output logic [pwsd_pkg::BIN_W-1:0]  out_start_time,
  output logic [pwsd_pkg::BIN_W-1:0]  out_pulse_width,
  output logic [pwsd_pkg::BIN_W-1:0]  out_end_time,
  output logic                     out_last
);
  import pwsd_pkg::*;

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LANES-1:0] pend_r, pend_nxt;
  logic [BIN_W-1:0] start_r [LANES];
  logic [BIN_W-1:0] end_r;

  logic [LANES-1:0] low;
  logic [LANES-1:0] rest;
  logic [LANES-1:0] new_mask;
  logic [IDX_W-1:0] sel_idx;
  logic [BIN_W-1:0] sel_start;
  logic             pop;

  logic             out_valid_r, out_valid_nxt;
  logic [LANE_W-1:0] lane_r;
  logic [BIN_W-1:0] ostart_r;
  logic [BIN_W-1:0] owidth_r;
  logic [BIN_W-1:0] oend_r;
  logic             olast_r;

  // Lowest pending lane and what remains after it.
  assign low  = pend_r & (~pend_r + LANES'(1));
  assign rest = pend_r & ~low;
  assign pop  = (pend_r != '0) && (!out_valid_r || out_ready);

  // A new word is taken once the current batch is empty or leaves now.
  assign take_ok = (pend_r == '0) || ((rest == '0) && pop);

  // One-hot selection of the lowest pending lane.
  always_comb begin
    sel_idx   = '0;
    sel_start = '0;
    for (int i = 0; i < LANES; i++) begin
      new_mask[i] = lane_res[i].acc;
      if (low[i]) begin
        sel_idx   = sel_idx | IDX_W'(i);
        sel_start = sel_start | start_r[i];
      end
    end
  end

  // Pending mask: loaded with a new bin, else drained one lane at a time.
  always_comb begin
    pend_nxt = pend_r;
    if (load) begin
      pend_nxt = new_mask;
    end else if (pop) begin
      pend_nxt = rest;
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Batch payload capture.
  always_ff @(posedge clk) begin
    if (load) begin
      end_r <= end_bin;
      for (int i = 0; i < LANES; i++) begin
        start_r[i] <= lane_res[i].start;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      lane_r   <= LANE_W'(sel_idx);
      ostart_r <= sel_start;
      owidth_r <= end_r - sel_start;
      oend_r   <= end_r;
      olast_r  <= (rest == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lane        = lane_r;
  assign out_start_time  = ostart_r;
  assign out_pulse_width = owidth_r;
  assign out_end_time    = oend_r;
  assign out_last        = olast_r;

endmodule

// ===== sv/pulse_width_span_discriminator.sv =====
// An accepted bin is loaded into the merge stage's pending mask; its first
// pulse then enters the output register, where it can be taken. Throughput:
// one bin per cycle while out_ready is high and each bin yields at most one
// accepted pulse; extra pulses stall the input, one word per cycle while ready.
// Synchronous active-low reset clears all lane state, the pending batch and
// the output valid, and sets the thresholds to 10 and 50.
// ----------------------------------------------------------------------------
// pulse_width_span_discriminator
// Per-lane pulse width discriminator with a start-to-start dead-time window.
// Lanes track edges in parallel; the merge stage serializes accepted pulses.
// ----------------------------------------------------------------------------
module pulse_width_span_discriminator #(
  parameter int LANES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_frame_start,
  input  logic [12:0] in_time_bin,
  input  logic [63:0] in_channel_bits,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_lane,
  output logic [12:0] out_start_time,
  output logic [12:0] out_pulse_width,
  output logic [12:0] out_end_time,
  output logic        out_last
);
  import pwsd_pkg::*;

  logic [BIN_W-1:0] min_width_r, min_width_nxt;
  logic [BIN_W-1:0] min_span_r, min_span_nxt;
  logic             cfg_wr;
  logic             in_acc;
  logic             bin_ok;
  pwsd_cfg_t        cfg;
  pwsd_step_t       step;
  pwsd_lane_res_t   lane_res [LANES];

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    min_width_nxt = min_width_r;
    min_span_nxt  = min_span_r;
    if (cfg_wr) begin
      case (paddr[2:2])
        REG_MIN_WIDTH: min_width_nxt = pwdata[BIN_W-1:0];
        REG_MIN_SPAN:  min_span_nxt  = pwdata[BIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r <= MIN_WIDTH_RST;
      min_span_r  <= MIN_SPAN_RST;
    end else begin
      min_width_r <= min_width_nxt;
      min_span_r  <= min_span_nxt;
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[2:2])
      REG_MIN_WIDTH: prdata = DATA_W'(min_width_r);
      REG_MIN_SPAN:  prdata = DATA_W'(min_span_r);
      default:       prdata = '0;
    endcase
  end

  // Step command broadcast to the lanes.
  assign in_acc        = in_valid && in_ready;
  assign bin_ok        = (32'(in_time_bin) < 32'(TIME_BINS));
  assign cfg.min_width = min_width_r;
  assign cfg.min_span  = min_span_r;
  assign step.clear    = in_acc && in_frame_start;
  assign step.process  = in_acc && bin_ok;
  assign step.bin      = in_time_bin;

  // Lane array.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pwsd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (cfg),
      .step  (step),
      .hit   (in_channel_bits[g]),
      .res   (lane_res[g])
    );
  end

  // Merge of lane results into the output stream.
  pwsd_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step.process),
    .end_bin         (in_time_bin),
    .lane_res        (lane_res),
    .take_ok         (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lane        (out_lane),
    .out_start_time  (out_start_time),
    .out_pulse_width (out_pulse_width),
    .out_end_time    (out_end_time),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  // A result word always carries a width equal to end minus start.
  a_width_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pulse_width == 13'(out_end_time - out_start_time)))
    else $error("pulse width does not match end minus start");

  // Input stalls only while pulses are pending, so the output fills next.
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid)
    else $error("input stalled with no pending results");

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
